// File: sv/aes_cipher_round_unit_defines.svh
// Assertion macros for the AES round unit.
// No dependencies.
`ifndef AES_CIPHER_ROUND_UNIT_DEFINES_SVH
`define AES_CIPHER_ROUND_UNIT_DEFINES_SVH
// assert that an antecedent implies a consequent in the next cycle
`define ACR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// assert that a condition holds on every enabled edge
`define ACR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

// File: sv/acr_pkg.sv
// Shared types and GF(2^8) helpers for the AES round unit.
// No dependencies.
`default_nettype none
package acr_pkg;
  localparam logic [1:0] OP_FULL  = 2'd0;
  localparam logic [1:0] OP_FINAL = 2'd1;
  localparam logic [1:0] OP_KEY   = 2'd2;
  // undefined code, decodes as key add only
  localparam logic [1:0] OP_RSVD  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] state_hi;
    logic [63:0] state_lo;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } acr_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } acr_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    gf_dbl = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction
endpackage
`default_nettype wire

// File: sv/acr_datapath.sv
// Combinational AES round: SubBytes, ShiftRows, MixColumns, AddRoundKey;
// final op skips MixColumns, key ops add key only. Depends on acr_pkg.
`default_nettype none
module acr_datapath (
  input  acr_pkg::acr_in_t  din,
  output acr_pkg::acr_out_t dout
);
  import acr_pkg::*;

  logic [7:0] s [16];
  logic [7:0] k [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] r [16];
  logic [127:0] st, ky;

  assign st = {din.state_hi, din.state_lo};
  assign ky = {din.key_hi, din.key_lo};

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st[127 - 8*i -: 8];
      k[i] = ky[127 - 8*i -: 8];
    end
    // row r of each column comes from column (c + r) mod 4
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[c*4 + j] = SBOX[s[((c + j) % 4)*4 + j]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[c*4]     = gf_dbl(t[c*4]) ^ gf_dbl(t[c*4+1]) ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
      m[c*4 + 1] = t[c*4] ^ gf_dbl(t[c*4+1]) ^ gf_dbl(t[c*4+2]) ^ t[c*4+2] ^ t[c*4+3];
      m[c*4 + 2] = t[c*4] ^ t[c*4+1] ^ gf_dbl(t[c*4+2]) ^ gf_dbl(t[c*4+3]) ^ t[c*4+3];
      m[c*4 + 3] = gf_dbl(t[c*4]) ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ gf_dbl(t[c*4+3]);
    end
    for (int i = 0; i < 16; i++) begin
      if (din.op[1]) begin
        r[i] = s[i] ^ k[i];
      end else if (din.op == OP_FULL) begin
        r[i] = m[i] ^ k[i];
      end else begin
        r[i] = t[i] ^ k[i];
      end
    end
    for (int i = 0; i < 8; i++) begin
      dout.result_hi[63 - 8*i -: 8] = r[i];
      dout.result_lo[63 - 8*i -: 8] = r[i + 8];
    end
  end
endmodule
`default_nettype wire

// File: sv/aes_cipher_round_unit.sv
// AES-128 encryption round unit: one input register, one result register.
// An input beat is held in the input register, then its round result in the result register.
// Throughput: one beat per cycle while the output is ready, set by the single round datapath between registers.
// The result register is a skid-free stage: input ready follows output readiness or an empty stage.
// Reset (rst_n low, synchronous) clears both valid flags; payload holds no reset.
// Depends on acr_pkg, acr_datapath and aes_cipher_round_unit_defines.svh.
`default_nettype none
module aes_cipher_round_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  acr_pkg::acr_in_t  in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output acr_pkg::acr_out_t out_data
);
  import acr_pkg::*;
  `include "aes_cipher_round_unit_defines.svh"

  acr_in_t  in_r;
  logic     in_vld_r;
  acr_out_t res_r, res_nxt;
  logic     res_vld_r;
  logic     adv;

  // advance the stage pair whenever the result slot is empty or being drained
  assign adv      = !res_vld_r || out_ready;
  assign in_ready = adv || !in_vld_r;

  acr_datapath u_dp (.din(in_r), .dout(res_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        res_vld_r <= in_vld_r;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld_r) begin
      res_r <= res_nxt;
    end
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  // hold a stalled result
  `ACR_ASSERT_NEXT(a_res_hold, clk, rst_n, res_vld_r && !out_ready, res_vld_r && $stable(res_r), "result changed under stall")
  // drop no item: a full input stage with a stalled output blocks input
  `ACR_ASSERT_ALWAYS(a_no_overrun, clk, rst_n, !(in_vld_r && res_vld_r && !out_ready) || !in_ready, "input accepted while both stages full")
endmodule
`default_nettype wire
